// File: design/path_meta_header_step_top_macros.svh
// ----------------------------------------------------------------------------
// Path meta header step: assertion macros
// Shared concurrent assertion forms. They sample on clk and are disabled
// while rst_n is low, so they are used inside modules with those ports.
// ----------------------------------------------------------------------------
`ifndef PATH_META_HEADER_STEP_TOP_MACROS_SVH
`define PATH_META_HEADER_STEP_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PMHS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PMHS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/pmhs_pkg.sv
// ----------------------------------------------------------------------------
// Path meta header step: package
// Field layout, byte sizes, operation and status codes, the stage records
// and the hop-to-segment lookup shared by the operation and flag stages.
// ----------------------------------------------------------------------------
package pmhs_pkg;

    // Byte sizes of the header parts.
    localparam int META_BYTES = 4;
    localparam int INFO_BYTES = 8;
    localparam int HOP_BYTES  = 12;

    // Field widths.
    localparam int WORD_W  = 32;
    localparam int OP_W    = 2;
    localparam int INF_W   = 2;
    localparam int HOP_W   = 6;
    localparam int LEN_W   = 6;
    localparam int NSEG_W  = 2;
    localparam int CNT_W   = 8;
    localparam int BYTES_W = 12;

    // Field positions inside the meta word.
    localparam int INF_LSB  = 30;
    localparam int HOP_LSB  = 24;
    localparam int LEN0_LSB = 12;
    localparam int LEN1_LSB = 6;
    localparam int LEN2_LSB = 0;

    // Operation codes; the unused code behaves as a query.
    localparam logic [OP_W-1:0] OP_QUERY   = 2'd0;
    localparam logic [OP_W-1:0] OP_ADVANCE = 2'd1;
    localparam logic [OP_W-1:0] OP_REVERSE = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_AT_END    = 2'd2,
        ST_MALFORMED = 2'd3
    } status_t;

    typedef logic [LEN_W-1:0] len_t;

    // Decoded header, first stage to second stage.
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [WORD_W-1:0] word;
        logic [INF_W-1:0]  inf;
        logic [HOP_W-1:0]  hf;
        len_t              len0;
        len_t              len1;
        len_t              len2;
        logic [NSEG_W-1:0] nseg;
        logic [CNT_W-1:0]  hops;
        logic              bad;
    } dec_t;

    // Header after the operation, second stage to third stage.
    typedef struct packed {
        logic [WORD_W-1:0]  word;
        logic [NSEG_W-1:0]  nseg;
        logic [CNT_W-1:0]   hops;
        logic [BYTES_W-1:0] bytes;
        logic [INF_W-1:0]   inf;
        logic [HOP_W-1:0]   hf;
        len_t               b0;
        logic [LEN_W:0]     b01;
        status_t            status;
    } app_t;

    // Finished result.
    typedef struct packed {
        logic [WORD_W-1:0]  new_meta_word;
        logic [NSEG_W-1:0]  segment_count;
        logic [CNT_W-1:0]   hop_count;
        logic [BYTES_W-1:0] path_bytes;
        logic               is_crossover;
        logic               is_first_after_crossover;
        logic               is_last_hop;
        logic               is_penultimate_hop;
        logic               is_first_hop;
        status_t            status;
    } res_t;

    // Segment holding a hop, given the end of the first segment (b0) and
    // the end of the second segment (b01).
    function automatic logic [INF_W-1:0] seg_of_hop(
        input logic [HOP_W:0] hop,
        input len_t           b0,
        input logic [LEN_W:0] b01
    );
        logic [INF_W-1:0] seg;
        if (hop < {1'b0, b0}) begin
            seg = 2'd0;
        end else if (hop < b01) begin
            seg = 2'd1;
        end else begin
            seg = 2'd2;
        end
        return seg;
    endfunction

endpackage

// File: design/pmhs_hdr_if.sv
// ----------------------------------------------------------------------------
// Path meta header step: header channel
// Carries one operation and one meta word per beat.
// ----------------------------------------------------------------------------
interface pmhs_hdr_if import pmhs_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [WORD_W-1:0] meta_word;

    modport source (output valid, output op, output meta_word, input ready);
    modport sink (input valid, input op, input meta_word, output ready);

endinterface

// File: design/pmhs_res_if.sv
// ----------------------------------------------------------------------------
// Path meta header step: result channel
// Carries the updated meta word, counts, flags and status per beat.
// ----------------------------------------------------------------------------
interface pmhs_res_if import pmhs_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [WORD_W-1:0]  new_meta_word;
    logic [NSEG_W-1:0]  segment_count;
    logic [CNT_W-1:0]   hop_count;
    logic [BYTES_W-1:0] path_bytes;
    logic               is_crossover;
    logic               is_first_after_crossover;
    logic               is_last_hop;
    logic               is_penultimate_hop;
    logic               is_first_hop;
    logic [1:0]         status;

    modport source (
        output valid, output new_meta_word, output segment_count, output hop_count,
        output path_bytes, output is_crossover, output is_first_after_crossover,
        output is_last_hop, output is_penultimate_hop, output is_first_hop,
        output status, input ready
    );
    modport sink (
        input valid, input new_meta_word, input segment_count, input hop_count,
        input path_bytes, input is_crossover, input is_first_after_crossover,
        input is_last_hop, input is_penultimate_hop, input is_first_hop,
        input status, output ready
    );

endinterface

// File: design/path_meta_header_step_top.sv
// ----------------------------------------------------------------------------
// Path meta header step: top level
// Three-stage pipeline that queries, advances or reverses a path meta
// header word and reports its counts, byte length and hop position flags.
//
//   Channel  Role    Beat contents
//   -------  ------  --------------------------------------------------------
//   hdr      sink    op, meta_word
//   res      source  new_meta_word, counts, path_bytes, hop flags, status
//
// Each beat passes through the decode, operation and flags stages in turn.
// One beat is taken per cycle while the result side keeps up.
// Reset clears the three stage valid bits; payload registers keep no reset.
// A stage holds its beat while the next one is full and stalled, and an
// empty stage lets a new beat in, so a stalled result does not block hdr
// until all three stages are full.
// ----------------------------------------------------------------------------
`include "path_meta_header_step_top_macros.svh"

module path_meta_header_step_top import pmhs_pkg::*; (
    input logic      clk,
    input logic      rst_n,
    pmhs_hdr_if.sink   hdr,
    pmhs_res_if.source res
);

    logic s1_valid;
    logic s1_ready;
    dec_t s1_data;
    logic s2_valid;
    logic s2_ready;
    app_t s2_data;
    logic s3_ready;
    res_t s3_data;

    // Stage one: field decode and counts.
    pmhs_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (hdr.valid),
        .up_ready  (hdr.ready),
        .op        (hdr.op),
        .meta_word (hdr.meta_word),
        .dn_valid  (s1_valid),
        .dn_ready  (s1_ready),
        .dn_data   (s1_data)
    );

    // Stage two: the operation itself.
    pmhs_apply u_apply (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s1_valid),
        .up_ready (s1_ready),
        .up_data  (s1_data),
        .dn_valid (s2_valid),
        .dn_ready (s2_ready),
        .dn_data  (s2_data)
    );

    // Stage three: position flags and the result register.
    pmhs_flags u_flags (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s2_valid),
        .up_ready (s2_ready),
        .up_data  (s2_data),
        .dn_valid (res.valid),
        .dn_ready (s3_ready),
        .dn_data  (s3_data)
    );

    // Result channel fields.
    assign s3_ready                     = res.ready;
    assign res.new_meta_word            = s3_data.new_meta_word;
    assign res.segment_count            = s3_data.segment_count;
    assign res.hop_count                = s3_data.hop_count;
    assign res.path_bytes               = s3_data.path_bytes;
    assign res.is_crossover             = s3_data.is_crossover;
    assign res.is_first_after_crossover = s3_data.is_first_after_crossover;
    assign res.is_last_hop              = s3_data.is_last_hop;
    assign res.is_penultimate_hop       = s3_data.is_penultimate_hop;
    assign res.is_first_hop             = s3_data.is_first_hop;
    assign res.status                   = s3_data.status;

    // A beat taken on hdr occupies the decode stage in the next cycle.
    `PMHS_ASSERT_NEXT(a_take_fills_s1, hdr.valid && hdr.ready, s1_valid, "beat lost at decode")
    // A full operation stage that cannot drain keeps its beat.
    `PMHS_ASSERT_NEXT(a_s2_holds, s2_valid && !s2_ready, s2_valid, "beat dropped in stage two")
    // Clamping at the path end leaves the hop on the last hop.
    `PMHS_ASSERT_NOW(a_end_is_last, res.valid && (res.status == ST_AT_END),
        res.is_last_hop, "clamp missed last hop")
    // No segments exactly when no hops.
    `PMHS_ASSERT_NOW(a_empty_counts, res.valid,
        (res.segment_count == '0) == (res.hop_count == '0), "counts disagree")

endmodule

// File: design/pmhs_decode.sv
// ----------------------------------------------------------------------------
// Path meta header step: decode stage
// Unpacks the meta word, counts segments and hops, and checks the segment
// lengths for a zero length below a nonzero one.
// ----------------------------------------------------------------------------
module pmhs_decode import pmhs_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_ready,
    input  logic [OP_W-1:0]   op,
    input  logic [WORD_W-1:0] meta_word,
    output logic              dn_valid,
    input  logic              dn_ready,
    output dec_t              dn_data
);

    logic valid_reg;
    dec_t data_reg;
    dec_t data_next;
    len_t l0;
    len_t l1;
    len_t l2;

    // The stage takes a beat when it is empty or its content moves on.
    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    assign l0 = meta_word[LEN0_LSB +: LEN_W];
    assign l1 = meta_word[LEN1_LSB +: LEN_W];
    assign l2 = meta_word[LEN2_LSB +: LEN_W];

    // Field unpacking, segment count and hop total.
    always_comb
    begin
        data_next.op   = op;
        data_next.word = meta_word;
        data_next.inf  = meta_word[INF_LSB +: INF_W];
        data_next.hf   = meta_word[HOP_LSB +: HOP_W];
        data_next.len0 = l0;
        data_next.len1 = l1;
        data_next.len2 = l2;
        data_next.hops = CNT_W'(l0) + CNT_W'(l1) + CNT_W'(l2);
        if (l2 != '0) begin
            data_next.nseg = 2'd3;
        end else if (l1 != '0) begin
            data_next.nseg = 2'd2;
        end else if (l0 != '0) begin
            data_next.nseg = 2'd1;
        end else begin
            data_next.nseg = 2'd0;
        end
        data_next.bad = ((l0 == '0) && ((l1 != '0) || (l2 != '0)))
                     || ((l1 == '0) && (l2 != '0));
    end

    // Valid bit with reset; payload loads only with a beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// File: design/pmhs_apply.sv
// ----------------------------------------------------------------------------
// Path meta header step: operation stage
// Applies query, advance or reverse, sets the status, repacks the word and
// works out the path length in bytes.
// ----------------------------------------------------------------------------
module pmhs_apply import pmhs_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic up_valid,
    output logic up_ready,
    input  dec_t up_data,
    output logic dn_valid,
    input  logic dn_ready,
    output app_t dn_data
);

    logic             valid_reg;
    app_t             data_reg;
    app_t             data_next;
    logic [HOP_W:0]   hf_inc;
    logic [HOP_W-1:0] hf_last;
    logic [LEN_W:0]   b01_in;
    logic             at_end;
    logic [INF_W-1:0] inf_new;
    logic [HOP_W-1:0] hf_new;
    len_t             n0;
    len_t             n1;
    len_t             n2;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    assign hf_inc  = {1'b0, up_data.hf} + (HOP_W+1)'(1);
    assign hf_last = up_data.hops[HOP_W-1:0] - HOP_W'(1);
    assign b01_in  = {1'b0, up_data.len0} + {1'b0, up_data.len1};
    assign at_end  = ({1'b0, hf_inc} >= up_data.hops);

    // New indexes and segment lengths for the operation.
    always_comb
    begin
        inf_new = up_data.inf;
        hf_new  = up_data.hf;
        n0      = up_data.len0;
        n1      = up_data.len1;
        n2      = up_data.len2;
        if (!up_data.bad && (up_data.nseg != '0)) begin
            case (up_data.op)
                OP_ADVANCE:
                begin
                    if (at_end) begin
                        hf_new = hf_last;
                    end else begin
                        hf_new  = hf_inc[HOP_W-1:0];
                        inf_new = seg_of_hop({1'b0, hf_inc[HOP_W-1:0]}, up_data.len0, b01_in);
                    end
                end
                OP_REVERSE:
                begin
                    inf_new = up_data.nseg - INF_W'(1) - up_data.inf;
                    hf_new  = hf_last - up_data.hf;
                    if (up_data.nseg == 2'd3) begin
                        n0 = up_data.len2;
                        n2 = up_data.len0;
                    end else if (up_data.nseg == 2'd2) begin
                        n0 = up_data.len1;
                        n1 = up_data.len0;
                    end
                end
                default:
                begin
                    inf_new = up_data.inf;
                end
            endcase
        end
    end

    // Status, repacked word and byte length.
    always_comb
    begin
        data_next.nseg = up_data.nseg;
        data_next.hops = up_data.hops;
        data_next.inf  = inf_new;
        data_next.hf   = hf_new;
        data_next.b0   = n0;
        data_next.b01  = {1'b0, n0} + {1'b0, n1};
        data_next.bytes = BYTES_W'(META_BYTES)
                        + BYTES_W'(up_data.nseg) * BYTES_W'(INFO_BYTES)
                        + BYTES_W'(up_data.hops) * BYTES_W'(HOP_BYTES);
        if (up_data.bad) begin
            data_next.status = ST_MALFORMED;
            data_next.word   = up_data.word;
        end else if (up_data.nseg == '0) begin
            data_next.status = ST_EMPTY;
            data_next.word   = up_data.word;
        end else begin
            data_next.status = ((up_data.op == OP_ADVANCE) && at_end) ? ST_AT_END : ST_OK;
            data_next.word   = '0;
            data_next.word[INF_LSB +: INF_W]  = inf_new;
            data_next.word[HOP_LSB +: HOP_W]  = hf_new;
            data_next.word[LEN0_LSB +: LEN_W] = n0;
            data_next.word[LEN1_LSB +: LEN_W] = n1;
            data_next.word[LEN2_LSB +: LEN_W] = n2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// File: design/pmhs_flags.sv
// ----------------------------------------------------------------------------
// Path meta header step: flag stage
// Derives the hop position flags from the header after the operation and
// holds the finished result for the result channel.
// ----------------------------------------------------------------------------
module pmhs_flags import pmhs_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic up_valid,
    output logic up_ready,
    input  app_t up_data,
    output logic dn_valid,
    input  logic dn_ready,
    output res_t dn_data
);

    logic             valid_reg;
    res_t             data_reg;
    res_t             data_next;
    logic [HOP_W:0]   hf_inc;
    logic [HOP_W-1:0] hf_dec;
    logic [CNT_W-1:0] hf_wide;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    assign hf_inc  = {1'b0, up_data.hf} + (HOP_W+1)'(1);
    assign hf_dec  = up_data.hf - HOP_W'(1);
    assign hf_wide = CNT_W'(up_data.hf);

    // Position flags relative to neighboring hops and the path ends.
    always_comb
    begin
        data_next.new_meta_word = up_data.word;
        data_next.segment_count = up_data.nseg;
        data_next.hop_count     = up_data.hops;
        data_next.path_bytes    = up_data.bytes;
        data_next.status        = up_data.status;
        data_next.is_crossover  = (CNT_W'(hf_inc) < up_data.hops)
            && (up_data.inf != seg_of_hop(hf_inc, up_data.b0, up_data.b01));
        data_next.is_first_after_crossover = (up_data.inf != '0) && (up_data.hf != '0)
            && ((up_data.inf - INF_W'(1))
                == seg_of_hop({1'b0, hf_dec}, up_data.b0, up_data.b01));
        data_next.is_last_hop = (up_data.hops != '0)
            && (hf_wide == up_data.hops - CNT_W'(1));
        data_next.is_penultimate_hop = (up_data.hops >= CNT_W'(2))
            && (hf_wide == up_data.hops - CNT_W'(2));
        data_next.is_first_hop = (up_data.hf == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid) begin
            data_reg <= data_next;
        end
    end

endmodule
